@@ rtl/core/tvc_pkg.sv @@
// ----------------------------------------------------------------------------
// tvc_pkg
// Shared widths, register map, reset values and interface types for the tilt
// vector conditioner.
// ----------------------------------------------------------------------------
package tvc_pkg;

	localparam int FRAC_BITS_DEF = 14;

	localparam int CNT_W  = 5;
	localparam int MUL_W  = 19;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 36;
	localparam int SUB_W  = 22;
	localparam int REM_W  = 20;
	localparam int MAG_W  = 18;
	localparam int DIV_W  = 19;
	localparam int QUO_W  = 16;
	localparam int GAIN_ONE = 65536;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int RIDX_W  = 3;

	localparam logic [RIDX_W-1:0] REG_OFFSET_X       = 3'd0;
	localparam logic [RIDX_W-1:0] REG_OFFSET_Y       = 3'd1;
	localparam logic [RIDX_W-1:0] REG_OFFSET_Z       = 3'd2;
	localparam logic [RIDX_W-1:0] REG_MIN_MAGNITUDE  = 3'd3;
	localparam logic [RIDX_W-1:0] REG_SMOOTHING_GAIN = 3'd4;
	localparam logic [RIDX_W-1:0] REG_DEADZONE       = 3'd5;
	localparam logic [RIDX_W-1:0] REG_OUTPUT_GAIN    = 3'd6;

	localparam logic [14:0] RST_MIN_MAGNITUDE  = 15'd1638;
	localparam logic [16:0] RST_SMOOTHING_GAIN = 17'd9830;
	localparam logic [14:0] RST_DEADZONE       = 15'd819;
	localparam logic [14:0] RST_OUTPUT_GAIN    = 15'd13107;

	typedef struct packed {
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [16:0] offset_z;
		logic        [14:0] min_magnitude;
		logic        [16:0] smoothing_gain;
		logic        [14:0] deadzone;
		logic        [14:0] output_gain;
	} cfg_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] mul_a;
		logic signed [MUL_W-1:0] mul_b;
		logic        [SUB_W-1:0] sub_a;
		logic        [SUB_W-1:0] sub_b;
	} alu_req_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic        [SUB_W-1:0]  diff;
		logic                     ge;
	} alu_rsp_t;

endpackage

@@ rtl/core/tilt_vector_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// tilt_vector_conditioner_top
// Offset removal, magnitude, normalization, smoothing, deadzone and gain of a
// three-axis accelerometer word, sequenced over one shared ALU.
//
//   channel  handshake            payload
//   -------  -------------------  ----------------------------------
//   in       in_valid / in_ready  raw_x, raw_y, raw_z
//   out      out_valid/out_ready  tilt_horizontal, tilt_vertical
//   apb      psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// A word passes through the 18-step square root on the shared subtractor
// and, when it is normalized, two bit-serial divides on the same unit.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the sequencer holds its last step while that
// register is still full. Reset loads the register defaults and arms the
// smoother to take the next word directly.
// ----------------------------------------------------------------------------
module tilt_vector_conditioner_top #(
	parameter int FRAC_BITS = tvc_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tvc_pkg::PADDR_W-1:0]  paddr,
	input  logic [tvc_pkg::PDATA_W-1:0]  pwdata,
	output logic [tvc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           raw_x,
	input  logic signed [15:0]           raw_y,
	input  logic signed [15:0]           raw_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           tilt_horizontal,
	output logic signed [15:0]           tilt_vertical
);
	import tvc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ     = 3'd1;
	localparam logic [2:0] ST_SQRT   = 3'd2;
	localparam logic [2:0] ST_DIVI   = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_SMOOTH = 3'd5;
	localparam logic [2:0] ST_MAP    = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	localparam logic [PROD_W-1:0] UNITY_P  = PROD_W'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0] OUT_HI_P = (FRAC_BITS >= 15) ? PROD_W'(32767) : UNITY_P;
	localparam logic [16:0]       GAIN_ONE_P = 17'(GAIN_ONE);

	cfg_t     cfg;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	// control
	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             axis_q;
	logic             first_q;
	logic             out_valid_q;
	logic signed [15:0] sx_q, sy_q;

	// datapath
	logic signed [16:0]      ax_q, ay_q;
	logic signed [17:0]      az_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [REM_W-1:0]        rem_q;
	logic [MAG_W-1:0]        root_q;
	logic [DIV_W-1:0]        r_q;
	logic [QUO_W-1:0]        quo_q;
	logic                    neg_q;
	logic signed [15:0]      nx_q, ny_q;
	logic signed [15:0]      hres_q, vres_q;
	logic signed [15:0]      th_q, tv_q;

	logic [SUB_W-1:0]        rem_nx;
	logic [QUO_W-1:0]        quo_nx;
	logic signed [15:0]      quo_val;
	logic signed [16:0]      div_src;
	logic [16:0]             g_sat, g_cmp;
	logic [16:0]             mx, my;
	logic signed [ACC_W-1:0] smooth_sum;
	logic                    out_free;

	tvc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tvc_alu u_alu (
		.clk (clk),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767)
			r = 16'sh7fff;
		else if (v < -17'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] w;
		w = 17'(v);
		return v[15] ? 17'(-w) : 17'(w);
	endfunction

	// deadzone, gain shift and clamp of one smoothed axis
	function automatic logic signed [15:0] map_out(
		input logic signed [PROD_W-1:0] prod,
		input logic signed [15:0]       s,
		input logic [16:0]              m,
		input logic [14:0]              dz
	);
		logic [PROD_W-1:0] vsh;
		logic [PROD_W-1:0] lim;
		logic [PROD_W-1:0] vv;
		logic signed [15:0] r;
		vsh = $unsigned(prod) >> FRAC_BITS;
		lim = s[15] ? UNITY_P : OUT_HI_P;
		vv  = (vsh > lim) ? lim : vsh;
		if (m <= 17'(dz))
			r = '0;
		else if (s[15])
			r = 16'(-vv);
		else
			r = 16'(vv);
		return r;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign tilt_horizontal = th_q;
	assign tilt_vertical   = tv_q;
	assign out_free  = !out_valid_q || out_ready;

	assign rem_nx = SUB_W'({rem_q, acc_q[ACC_W-1 -: 2]});
	assign quo_nx = {quo_q[QUO_W-2:0], alu_rsp.ge};
	assign quo_val = neg_q ? 16'(-(17'(quo_nx))) :
		((quo_nx > 16'd32767) ? 16'sh7fff : 16'(quo_nx));
	assign div_src = axis_q ? ay_q : ax_q;
	assign g_sat = (cfg.smoothing_gain > GAIN_ONE_P) ? GAIN_ONE_P : cfg.smoothing_gain;
	assign g_cmp = GAIN_ONE_P - g_sat;
	assign mx = abs16(sx_q);
	assign my = abs16(sy_q);
	assign smooth_sum = acc_q + ACC_W'(alu_rsp.prod);

	// operand select for the shared unit
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_SQ: begin
				case (cnt_q)
					CNT_W'(0): begin
						alu_req.mul_a = MUL_W'(ax_q);
						alu_req.mul_b = MUL_W'(ax_q);
					end
					CNT_W'(1): begin
						alu_req.mul_a = MUL_W'(ay_q);
						alu_req.mul_b = MUL_W'(ay_q);
					end
					default: begin
						alu_req.mul_a = MUL_W'(az_q);
						alu_req.mul_b = MUL_W'(az_q);
					end
				endcase
			end
			ST_SQRT: begin
				alu_req.sub_a = rem_nx;
				alu_req.sub_b = SUB_W'({root_q, 2'b01});
			end
			ST_DIV: begin
				alu_req.sub_a = SUB_W'(r_q);
				alu_req.sub_b = SUB_W'(root_q);
			end
			ST_SMOOTH: begin
				case (cnt_q)
					CNT_W'(0): begin
						alu_req.mul_a = MUL_W'(g_sat);
						alu_req.mul_b = MUL_W'(nx_q);
					end
					CNT_W'(1): begin
						alu_req.mul_a = MUL_W'(g_cmp);
						alu_req.mul_b = MUL_W'(sx_q);
					end
					CNT_W'(2): begin
						alu_req.mul_a = MUL_W'(g_sat);
						alu_req.mul_b = MUL_W'(ny_q);
					end
					default: begin
						alu_req.mul_a = MUL_W'(g_cmp);
						alu_req.mul_b = MUL_W'(sy_q);
					end
				endcase
			end
			ST_MAP: begin
				alu_req.mul_a = MUL_W'(cnt_q == CNT_W'(0) ? my : mx);
				alu_req.mul_b = MUL_W'(cfg.output_gain);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQ;
						cnt_q   <= '0;
					end
				end
				ST_SQ: begin
					if (cnt_q == CNT_W'(3)) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAG_W - 1)) begin
						state_q <= ST_DIVI;
						axis_q  <= 1'b0;
					end
				end
				ST_DIVI: begin
					if (root_q > MAG_W'(cfg.min_magnitude)) begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(FRAC_BITS);
					end else begin
						state_q <= ST_SMOOTH;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (axis_q)
							state_q <= ST_SMOOTH;
						else
							state_q <= ST_DIVI;
						axis_q <= 1'b1;
						cnt_q  <= '0;
					end else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_SMOOTH: begin
					if (first_q) begin
						// first word after reset loads the smoother
						sx_q    <= nx_q;
						sy_q    <= ny_q;
						first_q <= 1'b0;
						state_q <= ST_MAP;
						cnt_q   <= '0;
					end else if (cnt_q == CNT_W'(4)) begin
						sy_q    <= smooth_sum[31:16];
						state_q <= ST_MAP;
						cnt_q   <= '0;
					end else begin
						if (cnt_q == CNT_W'(2))
							sx_q <= smooth_sum[31:16];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MAP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ax_q  <= 17'(raw_x) - 17'(cfg.offset_x);
				ay_q  <= 17'(raw_y) - 17'(cfg.offset_y);
				az_q  <= 18'(raw_z) - 18'(cfg.offset_z);
				acc_q <= '0;
			end
			ST_SQ: begin
				if (cnt_q != '0)
					acc_q <= acc_q + ACC_W'(alu_rsp.prod);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				// one root bit per step, radicand shifted out of the accumulator
				acc_q <= acc_q << 2;
				if (alu_rsp.ge) begin
					rem_q  <= alu_rsp.diff[REM_W-1:0];
					root_q <= {root_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_nx[REM_W-1:0];
					root_q <= {root_q[MAG_W-2:0], 1'b0};
				end
			end
			ST_DIVI: begin
				neg_q <= div_src[16];
				r_q   <= DIV_W'(div_src[16] ? 17'(-div_src) : 17'(div_src));
				quo_q <= '0;
				if (!(root_q > MAG_W'(cfg.min_magnitude))) begin
					nx_q <= sat16(ax_q);
					ny_q <= sat16(ay_q);
				end
			end
			ST_DIV: begin
				quo_q <= quo_nx;
				r_q   <= (alu_rsp.ge ? alu_rsp.diff[DIV_W-1:0] : r_q) << 1;
				if (cnt_q == '0) begin
					if (axis_q)
						ny_q <= quo_val;
					else
						nx_q <= quo_val;
				end
			end
			ST_SMOOTH: begin
				if (cnt_q == CNT_W'(1) || cnt_q == CNT_W'(3))
					acc_q <= ACC_W'(alu_rsp.prod);
				else
					acc_q <= '0;
			end
			ST_MAP: begin
				if (cnt_q == CNT_W'(1))
					hres_q <= map_out(alu_rsp.prod, sy_q, my, cfg.deadzone);
				if (cnt_q == CNT_W'(2))
					vres_q <= map_out(alu_rsp.prod, sx_q, mx, cfg.deadzone);
			end
			ST_DONE: begin
				if (out_free) begin
					th_q <= hres_q;
					tv_q <= vres_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/tvc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tvc_cfg_regs
// APB register file: offsets, thresholds and gains of the conditioner.
// ----------------------------------------------------------------------------
module tvc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tvc_pkg::PADDR_W-1:0]  paddr,
	input  logic [tvc_pkg::PDATA_W-1:0]  pwdata,
	output logic [tvc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output tvc_pkg::cfg_t                cfg
);
	import tvc_pkg::*;

	cfg_t              cfg_q;
	logic [RIDX_W-1:0] ridx;
	logic              wr_en;

	assign pready = 1'b1;
	assign ridx   = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x       <= '0;
			cfg_q.offset_y       <= '0;
			cfg_q.offset_z       <= '0;
			cfg_q.min_magnitude  <= RST_MIN_MAGNITUDE;
			cfg_q.smoothing_gain <= RST_SMOOTHING_GAIN;
			cfg_q.deadzone       <= RST_DEADZONE;
			cfg_q.output_gain    <= RST_OUTPUT_GAIN;
		end else if (wr_en) begin
			unique case (ridx)
				REG_OFFSET_X:       cfg_q.offset_x       <= pwdata[15:0];
				REG_OFFSET_Y:       cfg_q.offset_y       <= pwdata[15:0];
				REG_OFFSET_Z:       cfg_q.offset_z       <= pwdata[16:0];
				REG_MIN_MAGNITUDE:  cfg_q.min_magnitude  <= pwdata[14:0];
				REG_SMOOTHING_GAIN: cfg_q.smoothing_gain <= pwdata[16:0];
				REG_DEADZONE:       cfg_q.deadzone       <= pwdata[14:0];
				REG_OUTPUT_GAIN:    cfg_q.output_gain    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_OFFSET_X:       prdata = PDATA_W'(cfg_q.offset_x);
			REG_OFFSET_Y:       prdata = PDATA_W'(cfg_q.offset_y);
			REG_OFFSET_Z:       prdata = PDATA_W'(cfg_q.offset_z);
			REG_MIN_MAGNITUDE:  prdata = PDATA_W'(cfg_q.min_magnitude);
			REG_SMOOTHING_GAIN: prdata = PDATA_W'(cfg_q.smoothing_gain);
			REG_DEADZONE:       prdata = PDATA_W'(cfg_q.deadzone);
			REG_OUTPUT_GAIN:    prdata = PDATA_W'(cfg_q.output_gain);
			default:            prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/tvc_alu.sv @@
// ----------------------------------------------------------------------------
// tvc_alu
// Shared arithmetic: one signed multiplier with a registered product and one
// subtract/compare used by the square root and the divider.
// ----------------------------------------------------------------------------
module tvc_alu (
	input  logic              clk,
	input  tvc_pkg::alu_req_t req,
	output tvc_pkg::alu_rsp_t rsp
);
	import tvc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
	end

	assign rsp.prod = prod_q;
	assign rsp.diff = req.sub_a - req.sub_b;
	assign rsp.ge   = (req.sub_a >= req.sub_b);

endmodule

@@ bench/tilt_vector_conditioner_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_vector_conditioner_top_test
// Self-checking bench: raw accelerometer words go in under random sender gaps
// and receiver stalls, the APB registers are reprogrammed between phases, and
// every result word is compared with a bit-accurate predictor in the bench.
// ----------------------------------------------------------------------------
module tilt_vector_conditioner_top_test;
	import tvc_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint UNITY = longint'(1) << FRAC;
	localparam longint OUT_HI = (UNITY > 32767) ? 32767 : UNITY;
	localparam longint GAIN_FULL = GAIN_ONE;
	localparam logic [RIDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 80;
	localparam int MAX_REPORTS = 10;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 130;

	typedef struct packed {
		logic signed [15:0] horiz;
		logic signed [15:0] vert;
	} tilt_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [15:0] raw_x, raw_y, raw_z;
	logic out_valid, out_ready;
	logic signed [15:0] tilt_horizontal, tilt_vertical;

	// bench copy of the registers and smoother
	cfg_t cfg_model;
	logic signed [15:0] filt_x, filt_y;
	logic load_next;

	tilt_t expected_tilt[$];
	int mismatches = 0;
	int cycles = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;

	tilt_vector_conditioner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_x(raw_x),
		.raw_y(raw_y),
		.raw_z(raw_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tilt_horizontal(tilt_horizontal),
		.tilt_vertical(tilt_vertical)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 3);
		else if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(16, 80);
	endfunction

	function automatic longint floor_sqrt(input longint n);
		longint root, trial;
		int b;
		root = 0;
		for (b = 20; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic longint to_unit(input longint a, input longint mag);
		longint q;
		q = ((a < 0 ? -a : a) * UNITY) / mag;
		return (a < 0) ? -q : q;
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// floor((g*a + (1-g)*s)), g in Q1.16
	function automatic logic signed [15:0] ema_step(input longint a,
			input logic signed [15:0] s, input longint g);
		longint sum;
		sum = g * a + (GAIN_FULL - g) * longint'(s);
		return 16'(sum >>> 16);
	endfunction

	function automatic logic signed [15:0] screen_axis(input logic signed [15:0] s);
		longint m, v;
		m = (s < 0) ? -longint'(s) : longint'(s);
		if (m <= longint'(cfg_model.deadzone))
			return 16'sd0;
		v = (m * longint'(cfg_model.output_gain)) >>> FRAC;
		if (s < 0)
			v = -v;
		if (v > OUT_HI)
			v = OUT_HI;
		if (v < -UNITY)
			v = -UNITY;
		return 16'(v);
	endfunction

	// advances the bench smoother and returns the result word for one sample
	function automatic tilt_t predict_tilt(input logic signed [15:0] rx, ry, rz);
		longint ax, ay, az, sq, mag, g;
		tilt_t r;
		ax = longint'(rx) - longint'($signed(cfg_model.offset_x));
		ay = longint'(ry) - longint'($signed(cfg_model.offset_y));
		az = longint'(rz) - longint'($signed(cfg_model.offset_z));
		sq = ax * ax + ay * ay + az * az;
		mag = floor_sqrt(sq);
		if (mag > longint'(cfg_model.min_magnitude)) begin
			ax = to_unit(ax, mag);
			ay = to_unit(ay, mag);
		end
		ax = clamp16(ax);
		ay = clamp16(ay);
		g = (cfg_model.smoothing_gain > GAIN_ONE) ? GAIN_FULL
			: longint'(cfg_model.smoothing_gain);
		if (load_next) begin
			filt_x = 16'(ax);
			filt_y = 16'(ay);
			load_next = 1'b0;
		end else begin
			filt_x = ema_step(ax, filt_x, g);
			filt_y = ema_step(ay, filt_y, g);
		end
		r.horiz = screen_axis(filt_y);
		r.vert = screen_axis(filt_x);
		return r;
	endfunction

	task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OFFSET_X:       cfg_model.offset_x = value[15:0];
			REG_OFFSET_Y:       cfg_model.offset_y = value[15:0];
			REG_OFFSET_Z:       cfg_model.offset_z = value[16:0];
			REG_MIN_MAGNITUDE:  cfg_model.min_magnitude = value[14:0];
			REG_SMOOTHING_GAIN: cfg_model.smoothing_gain = value[16:0];
			REG_DEADZONE:       cfg_model.deadzone = value[14:0];
			REG_OUTPUT_GAIN:    cfg_model.output_gain = value[14:0];
			default: ;
		endcase
	endtask

	// bits above each register's width carry junk; the unmapped slot gets a write too
	task automatic load_config(input cfg_t c);
		write_reg(REG_OFFSET_X, {16'($urandom), c.offset_x});
		write_reg(REG_OFFSET_Y, {16'($urandom), c.offset_y});
		write_reg(REG_OFFSET_Z, {15'($urandom), c.offset_z});
		write_reg(REG_MIN_MAGNITUDE, {17'($urandom), c.min_magnitude});
		write_reg(REG_SMOOTHING_GAIN, {15'($urandom), c.smoothing_gain});
		write_reg(REG_DEADZONE, {17'($urandom), c.deadzone});
		write_reg(REG_OUTPUT_GAIN, {17'($urandom), c.output_gain});
		write_reg(REG_UNMAPPED, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(input logic signed [15:0] x, y, z);
		int gap;
		gap = tx_gaps ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		do @(posedge clk); while (!in_ready);
		expected_tilt.push_back(predict_tilt(x, y, z));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tilt.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_edge(input int w, input bit sgn);
		case ($urandom_range(0, 2))
			0: return sgn ? (32'd1 << (w - 1)) : 32'd0;
			1: return sgn ? (32'd1 << (w - 1)) - 1 : (32'd1 << w) - 1;
			default: return $urandom & ((32'd1 << w) - 1);
		endcase
	endfunction

	function automatic cfg_t plausible_config();
		cfg_t c;
		c.offset_x = 16'(int'($urandom_range(0, 1000)) - 500);
		c.offset_y = 16'(int'($urandom_range(0, 1000)) - 500);
		c.offset_z = 17'(int'($urandom_range(0, 4000)) - 2000);
		c.min_magnitude = 15'($urandom_range(0, 3000));
		c.smoothing_gain = 17'($urandom_range(1000, 65536));
		c.deadzone = 15'($urandom_range(0, 2000));
		c.output_gain = 15'($urandom_range(8000, 16384));
		return c;
	endfunction

	function automatic cfg_t edge_config();
		cfg_t c;
		c.offset_x = 16'(pick_edge(16, 1'b1));
		c.offset_y = 16'(pick_edge(16, 1'b1));
		c.offset_z = 17'(pick_edge(17, 1'b1));
		c.min_magnitude = 15'(pick_edge(15, 1'b0));
		c.smoothing_gain = 17'(pick_edge(17, 1'b0));
		c.deadzone = 15'(pick_edge(15, 1'b0));
		c.output_gain = 15'(pick_edge(15, 1'b0));
		return c;
	endfunction

	function automatic logic signed [15:0] extreme_axis();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			4: return 16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] near(input logic signed [16:0] center, input int span);
		return 16'(int'(center) + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_word();
		int kind;
		logic signed [15:0] x, y, z;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			// roughly gravity-sized, around the programmed offsets
			x = near(17'($signed(cfg_model.offset_x)), 16384);
			y = near(17'($signed(cfg_model.offset_y)), 16384);
			z = near(cfg_model.offset_z, 16384);
		end else if (kind < 70) begin
			// around the normalize threshold and the deadzone
			x = near(17'($signed(cfg_model.offset_x)), 2500);
			y = near(17'($signed(cfg_model.offset_y)), 2500);
			z = near(cfg_model.offset_z, 2500);
		end else if (kind < 85) begin
			x = 16'($urandom);
			y = 16'($urandom);
			z = 16'($urandom);
		end else begin
			x = extreme_axis();
			y = extreme_axis();
			z = extreme_axis();
		end
		send_word(x, y, z);
	endtask

	task automatic test_power_on_defaults();
		// first word loads the smoother directly
		send_word(16'sd8000, -16'sd6000, 16'sd12000);
		send_word(16'sd0, 16'sd0, 16'sd0);
		send_word(16'sd32767, 16'sd32767, 16'sd32767);
		send_word(-16'sd32768, -16'sd32768, -16'sd32768);
		send_word(-16'sd32768, 16'sd32767, 16'sd0);
		send_word(16'sd1000, -16'sd1000, 16'sd500);
		// magnitude exactly at the threshold stays raw, one above normalizes
		send_word(16'sd1638, 16'sd0, 16'sd0);
		send_word(16'sd1639, 16'sd0, 16'sd0);
		send_word(16'sd0, 16'sd16384, 16'sd0);
		send_word(-16'sd16384, 16'sd0, 16'sd0);
	endtask

	task automatic test_gain_and_clamp();
		cfg_t c;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		drain_results();
		c = '0;
		c.min_magnitude = 15'h7FFF;
		c.smoothing_gain = 17'h1FFFF;	// saturates to unity, filter follows input
		c.deadzone = 15'd500;
		c.output_gain = 15'h7FFF;
		load_config(c);
		send_word(16'sd500, -16'sd500, 16'sd0);
		send_word(16'sd501, -16'sd501, 16'sd0);
		send_word(-16'sd20000, 16'sd20000, 16'sd0);
		send_word(16'sd32767, 16'sd0, 16'sd0);
		send_word(16'sd32767, 16'sd300, 16'sd0);
		drain_results();
		c.smoothing_gain = 17'd0;	// filter holds
		load_config(c);
		send_word(16'sd20000, -16'sd20000, 16'sd0);
		send_word(-16'sd3000, 16'sd3000, 16'sd0);
	endtask

	task automatic test_offset_extremes();
		cfg_t c;
		drain_results();
		c.offset_x = -16'sd32768;
		c.offset_y = 16'sd32767;
		c.offset_z = 17'h10000;
		c.min_magnitude = RST_MIN_MAGNITUDE;
		c.smoothing_gain = 17'h10000;
		c.deadzone = 15'd0;
		c.output_gain = 15'd16384;
		load_config(c);
		send_word(16'sd32767, -16'sd32768, 16'sd32767);
		send_word(-16'sd32768, 16'sd32767, -16'sd32768);
		drain_results();
		c.offset_x = 16'sd32767;
		c.offset_y = -16'sd32768;
		c.offset_z = 17'h0FFFF;
		load_config(c);
		send_word(-16'sd32768, 16'sd32767, -16'sd32768);
		send_word(16'sd32767, -16'sd32768, 16'sd32767);
	endtask

	task automatic test_random_phases();
		int phase, n;
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			load_config((phase % 3 == 2) ? edge_config() : plausible_config());
			tx_gaps = (phase != 1) && (phase != 6);
			rx_stalls = (phase != 1) && (phase != 4);
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				if (phase == 3 && n == WORDS_PER_PHASE / 2)
					drain_results();
				random_word();
			end
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		raw_x = '0;
		raw_y = '0;
		raw_z = '0;
		arst_n = 1'b0;
		cfg_model = '0;
		cfg_model.min_magnitude = RST_MIN_MAGNITUDE;
		cfg_model.smoothing_gain = RST_SMOOTHING_GAIN;
		cfg_model.deadzone = RST_DEADZONE;
		cfg_model.output_gain = RST_OUTPUT_GAIN;
		filt_x = '0;
		filt_y = '0;
		load_next = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_power_on_defaults();
		test_gain_and_clamp();
		test_offset_extremes();
		test_random_phases();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// receiver: ready in bursts, stalls of random length when enabled
	initial begin
		int run, gap;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = gap_len();
			if (rx_stalls && gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		tilt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tilt.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word at cycle %0d: horizontal %0d vertical %0d",
						cycles, tilt_horizontal, tilt_vertical);
			end else begin
				want = expected_tilt.pop_front();
				if (tilt_horizontal !== want.horiz || tilt_vertical !== want.vert) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch at cycle %0d: horizontal exp %0d got %0d, vertical exp %0d got %0d",
							cycles, want.horiz, tilt_horizontal, want.vert, tilt_vertical);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_tilt.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

@@ files.f @@
rtl/core/tvc_pkg.sv
rtl/core/tvc_cfg_regs.sv
rtl/core/tvc_alu.sv
rtl/core/tilt_vector_conditioner_top.sv
bench/tilt_vector_conditioner_top_test.sv
